// ===== rtl/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants of the reserved region table.
// ----------------------------------------------------------------------------
package rrt_pkg;

  // Default table depth
  localparam int unsigned MAX_RANGES_DEF = 16;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VA_W    = 47;
  localparam int unsigned PAGES_W = 36;
  localparam int unsigned LIM_W   = 48;
  localparam int unsigned GAP_W   = 32;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned PAGE_SH = 12;
  // Internal address arithmetic width (no sum overflows this)
  localparam int unsigned AW      = 51;

  // Config register port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;
  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_DFLT  = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RST = 48'h8000_0000_0000;
  localparam logic [VA_W-1:0]  DFLT_RST  = 47'h7FFF_0000_0000;
  localparam logic [GAP_W-1:0] GAP_RST   = 32'd4096;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK   = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK           = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_ARG      = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERLAP      = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL         = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_RESERVED = 3'd4;
  localparam logic [ST_W-1:0] ST_NO_SPACE     = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic pre;
    logic step;
    logic insert;
  } rrt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pre_done;
    logic scan_done;
    logic need_insert;
  } rrt_sts_t;

endpackage

// ===== rtl/rrt_if.sv =====
// ----------------------------------------------------------------------------
// rrt_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface rrt_req_if;
  import rrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VA_W-1:0]    base_address;
  logic [PAGES_W-1:0] page_count;
  modport source (output valid, operation, base_address, page_count, input ready);
  modport sink   (input valid, operation, base_address, page_count, output ready);
endinterface

interface rrt_rsp_if;
  import rrt_pkg::*;
  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic [VA_W-1:0] stack_base;
  modport source (output valid, status, stack_base, input ready);
  modport sink   (input valid, status, stack_base, output ready);
endinterface

// ===== rtl/rrt_regs.sv =====
// ----------------------------------------------------------------------------
// rrt_regs
// APB configuration registers: low-half limit, default stack base, gap.
// ----------------------------------------------------------------------------
module rrt_regs import rrt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [LIM_W-1:0]  limit_o,
  output logic [VA_W-1:0]   dflt_o,
  output logic [GAP_W-1:0]  gap_o
);

  logic [LIM_W-1:0] limit_q;
  logic [VA_W-1:0]  dflt_q;
  logic [GAP_W-1:0] gap_q;
  logic [1:0]       idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      dflt_q  <= DFLT_RST;
      gap_q   <= GAP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LIMIT: limit_q <= pwdata[LIM_W-1:0];
        REG_DFLT:  dflt_q  <= pwdata[VA_W-1:0];
        REG_GAP:   gap_q   <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_LIMIT: prdata = {{(APB_DW-LIM_W){1'b0}}, limit_q};
      REG_DFLT:  prdata = {{(APB_DW-VA_W){1'b0}}, dflt_q};
      REG_GAP:   prdata = {{(APB_DW-GAP_W){1'b0}}, gap_q};
      default:   prdata = '0;
    endcase
  end

  assign limit_o = limit_q;
  assign dflt_o  = dflt_q;
  assign gap_o   = gap_q;

endmodule

// ===== rtl/rrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrt_ctrl
// Sequencer: load, argument checks, table scan, insert, result hold.
// ----------------------------------------------------------------------------
module rrt_ctrl import rrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rrt_cmd_t cmd_o,
  input  rrt_sts_t sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        state_d   = sts_i.pre_done ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.need_insert ? S_INS : S_OUT;
        end
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rrt_dp.sv =====
// ----------------------------------------------------------------------------
// rrt_dp
// Datapath: sorted range table, one-entry-per-cycle scan, sorted insert.
// ----------------------------------------------------------------------------
module rrt_dp import rrt_pkg::*; #(
  parameter int unsigned MaxRanges = MAX_RANGES_DEF,
  localparam int unsigned CntW = $clog2(MaxRanges + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrt_cmd_t           cmd_i,
  output rrt_sts_t           sts_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [VA_W-1:0]    base_i,
  input  logic [PAGES_W-1:0] pages_i,
  input  logic [LIM_W-1:0]   limit_i,
  input  logic [VA_W-1:0]    dflt_i,
  input  logic [GAP_W-1:0]   gap_i,
  output logic [ST_W-1:0]    status_o,
  output logic [VA_W-1:0]    stack_base_o,
  output logic [CntW-1:0]    count_o
);

  localparam int unsigned IdxW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam logic [AW-1:0] PageMask = AW'(12'hFFF);
  localparam logic [AW-1:0] VaMax    = {{(AW-VA_W){1'b0}}, {VA_W{1'b1}}};

  logic [OP_W-1:0]    op_q;
  logic [VA_W-1:0]    base_q;
  logic [PAGES_W-1:0] pages_q;
  logic [AW-1:0]      cand_q;
  logic [CntW-1:0]    idx_q, at_q, count_q;
  logic [ST_W-1:0]    status_q;
  logic [VA_W-1:0]    sbase_q;
  logic [VA_W-1:0]    rb_q [MaxRanges];
  logic [PAGES_W-1:0] rp_q [MaxRanges];

  logic [AW-1:0]   pbytes, base_x, limit_x, rb, re, lb, le, cand_up, cand_init;
  logic            meet, at_end, hit, fin_bad, bad_arg, pre_fin;
  logic [ST_W-1:0] pre_st, hit_st;

  // operand views
  assign pbytes  = {{(AW-PAGES_W-PAGE_SH){1'b0}}, pages_q, {PAGE_SH{1'b0}}};
  assign base_x  = {{(AW-VA_W){1'b0}}, base_q};
  assign limit_x = {{(AW-LIM_W){1'b0}}, limit_i};

  // current table entry and overlap test
  assign rb = {{(AW-VA_W){1'b0}}, rb_q[idx_q[IdxW-1:0]]};
  assign re = rb + {{(AW-PAGES_W-PAGE_SH){1'b0}}, rp_q[idx_q[IdxW-1:0]], {PAGE_SH{1'b0}}};
  assign lb = (op_q == OP_SELECT) ? cand_q : base_x;
  assign le = lb + pbytes;
  assign meet   = !((le <= rb) || (re <= lb));
  assign at_end = (idx_q == count_q);

  // next first-fit candidate: past range end plus gap, page aligned up
  assign cand_up = (re + {{(AW-GAP_W){1'b0}}, gap_i} + PageMask) & ~PageMask;
  assign cand_init = {{(AW-VA_W){1'b0}}, ((base_q != '0) ? base_q : dflt_i)} & ~PageMask;
  assign fin_bad = ((cand_q + pbytes) > limit_x) || (cand_q > VaMax);

  // argument checks
  assign bad_arg = (pages_q == '0) || (base_q[PAGE_SH-1:0] != '0) ||
                   (base_x >= limit_x) || ((base_x + pbytes) > limit_x);

  always_comb begin
    pre_fin = 1'b1;
    pre_st  = ST_BAD_ARG;
    case (op_q)
      OP_RESERVE: begin
        if (bad_arg) begin
          pre_st = ST_BAD_ARG;
        end else if (count_q >= CntW'(MaxRanges)) begin
          pre_st = ST_FULL;
        end else begin
          pre_st  = ST_OK;
          pre_fin = 1'b0;
        end
      end
      OP_CHECK: begin
        pre_st  = ST_NOT_RESERVED;
        pre_fin = (pages_q == '0);
      end
      OP_SELECT: begin
        pre_st  = (pages_q == '0) ? ST_BAD_ARG : ST_OK;
        pre_fin = (pages_q == '0);
      end
      default: ;
    endcase
  end

  // per-entry decision
  always_comb begin
    hit    = 1'b0;
    hit_st = ST_OK;
    if (!at_end) begin
      case (op_q)
        OP_RESERVE: begin
          hit    = meet;
          hit_st = ST_OVERLAP;
        end
        OP_CHECK: begin
          hit    = (base_x >= rb) && ((base_x + pbytes) <= re);
          hit_st = ST_OK;
        end
        OP_SELECT: begin
          hit    = (base_q != '0) && meet;
          hit_st = ST_OVERLAP;
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  assign sts_o = '{pre_done:    pre_fin,
                   scan_done:   at_end || hit,
                   need_insert: at_end && (op_q == OP_RESERVE)};

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.insert) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      base_q  <= base_i;
      pages_q <= pages_i;
      sbase_q <= '0;
    end
    if (cmd_i.pre) begin
      status_q <= pre_st;
      idx_q    <= '0;
      at_q     <= count_q;
      cand_q   <= cand_init;
    end
    if (cmd_i.step) begin
      if (at_end) begin
        if (op_q == OP_SELECT) begin
          if (fin_bad) begin
            status_q <= ST_NO_SPACE;
          end else begin
            sbase_q <= cand_q[VA_W-1:0];
          end
        end
      end else if (hit) begin
        status_q <= hit_st;
      end else begin
        idx_q <= idx_q + CntW'(1);
        if ((op_q == OP_RESERVE) && (at_q == count_q) && (base_x < rb)) begin
          at_q <= idx_q;
        end
        if ((op_q == OP_SELECT) && meet) begin
          cand_q <= cand_up;
        end
      end
    end
  end

  // sorted insert: entries from the slot up to the fill shift by one
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      for (int unsigned j = 0; j < MaxRanges; j++) begin
        if (CntW'(j) == at_q) begin
          rb_q[j] <= base_q;
          rp_q[j] <= pages_q;
        end else if ((j > 0) && (CntW'(j) > at_q) && (CntW'(j) <= count_q)) begin
          rb_q[j] <= rb_q[(j > 0) ? j - 1 : 0];
          rp_q[j] <= rp_q[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  assign status_o     = status_q;
  assign stack_base_o = sbase_q;
  assign count_o      = count_q;

endmodule

// ===== rtl/reserved_region_table.sv =====
// ----------------------------------------------------------------------------
// reserved_region_table
// Sorted table of reserved virtual-address ranges with reserve, check and
// stack-base selection.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A request is loaded and its
// arguments are checked; unless the checks settle it, the scan then visits
// the stored ranges, one entry per cycle, until a hit or the end of the
// table, and a successful reserve is inserted before the response word is
// offered. The next request is taken once the response word has been
// accepted.
module reserved_region_table import rrt_pkg::*; #(
  parameter int unsigned MaxRanges = MAX_RANGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrt_req_if.sink           req_i,
  rrt_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CntW = $clog2(MaxRanges + 1);

  logic [LIM_W-1:0] limit;
  logic [VA_W-1:0]  dflt;
  logic [GAP_W-1:0] gap;
  logic [CntW-1:0]  count;
  rrt_cmd_t         cmd;
  rrt_sts_t         sts;

  rrt_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .limit_o (limit),
    .dflt_o  (dflt),
    .gap_o   (gap)
  );

  rrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rrt_dp #(.MaxRanges(MaxRanges)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (req_i.operation),
    .base_i       (req_i.base_address),
    .pages_i      (req_i.page_count),
    .limit_i      (limit),
    .dflt_i       (dflt),
    .gap_i        (gap),
    .status_o     (rsp_o.status),
    .stack_base_o (rsp_o.stack_base),
    .count_o      (count)
  );

  // a response is never pending while a new request is taken
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("request taken while response pending");

  // fill never exceeds depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(MaxRanges))
    else $error("range count beyond table depth");

  // table fill changes only on insert, where it moves by one
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.insert |=> $stable(count))
    else $error("range count changed without insert");

endmodule

// ===== verif/reserved_region_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reserved_region_table_tb
// Self-checking bench for the reserved region table. A short table of
// directed words (limits, alignment, overlap, containment, stack-base
// stepping) is followed by random reserve/check/select traffic over four
// register settings. Each response word is checked against its directed
// row's typed value or against a local copy of the bench's range table.
// ----------------------------------------------------------------------------
module reserved_region_table_tb;
  import rrt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned     DEPTH     = MAX_RANGES_DEF;
  localparam longint unsigned PG_BYTES  = 64'h1000;
  localparam longint unsigned VA_MASK   = 64'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [VA_W-1:0] stack_base;
  } region_rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VA_W-1:0]    base;
    logic [PAGES_W-1:0] pages;
    logic               typed;
    logic [ST_W-1:0]    status;
    logic [VA_W-1:0]    stack_base;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_CHECK,   47'h1000,           36'd1,            1'b1, ST_NOT_RESERVED, 47'd0},
    '{OP_RESERVE, 47'h1000,           36'd0,            1'b1, ST_BAD_ARG,      47'd0},
    '{OP_RESERVE, 47'h1001,           36'd1,            1'b1, ST_BAD_ARG,      47'd0},
    '{OP_RESERVE, 47'h7FFF_FFFF_F000, 36'hF_FFFF_FFFF,  1'b1, ST_BAD_ARG,      47'd0},
    '{OP_SELECT,  47'd0,              36'd0,            1'b1, ST_BAD_ARG,      47'd0},
    '{OP_SELECT,  47'd0,              36'd1,            1'b1, ST_OK, 47'h7FFF_0000_0000},
    '{OP_UNUSED,  47'h7FFF_FFFF_FFFF, 36'hF_FFFF_FFFF,  1'b1, ST_BAD_ARG,      47'd0},
    '{OP_SELECT,  47'h7FFF_FFFF_FFFF, 36'd1,            1'b1, ST_OK, 47'h7FFF_FFFF_F000},
    '{OP_SELECT,  47'h7FFF_FFFF_F000, 36'd2,            1'b1, ST_NO_SPACE,     47'd0},
    '{OP_RESERVE, 47'h7FFF_FFFF_F000, 36'd1,            1'b1, ST_OK,           47'd0},
    '{OP_RESERVE, 47'h1000,           36'd1,            1'b1, ST_OK,           47'd0},
    '{OP_RESERVE, 47'h1000,           36'd1,            1'b1, ST_OVERLAP,      47'd0},
    '{OP_CHECK,   47'h1000,           36'd1,            1'b1, ST_OK,           47'd0},
    '{OP_CHECK,   47'h1000,           36'd0,            1'b1, ST_NOT_RESERVED, 47'd0},
    '{OP_CHECK,   47'h1800,           36'd1,            1'b0, ST_OK,           47'd0},
    '{OP_SELECT,  47'h1FFF,           36'd1,            1'b1, ST_OVERLAP,      47'd0},
    '{OP_RESERVE, 47'h7FFF_0000_0000, 36'd2,            1'b0, ST_OK,           47'd0},
    '{OP_SELECT,  47'd0,              36'd1,            1'b0, ST_OK,           47'd0},
    '{OP_RESERVE, 47'd0,              36'h8_0000_0000,  1'b0, ST_OK,           47'd0},
    '{OP_CHECK,   47'd0,              36'hF_FFFF_FFFF,  1'b0, ST_OK,           47'd0}
  };

  logic clk_i;
  logic rst_ni;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  rrt_req_if req_ch ();
  rrt_rsp_if rsp_ch ();

  reserved_region_table DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch.sink),
    .rsp_o   (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the range table and registers
  longint unsigned lim_reg, dflt_reg, gap_reg;
  longint unsigned tbl_base  [DEPTH];
  longint unsigned tbl_pages [DEPTH];
  int unsigned     tbl_count;

  region_rsp_t pending_results [$];
  int          fail_count;
  int          words_seen;
  bit          drain_wait;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("** reserved_region_table: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp);
    $display("[%0t] mismatch %s: got 0x%0h exp 0x%0h", $realtime, what, got, exp);
    fail_count++;
  endtask

  function automatic bit spans_overlap(input longint unsigned lb, input longint unsigned lp,
                                       input longint unsigned rb, input longint unsigned rp);
    if (lp == 0 || rp == 0) return 1'b1;
    return !((lb + lp * PG_BYTES) <= rb || (rb + rp * PG_BYTES) <= lb);
  endfunction

  // Applies one request word to the local table and returns its response
  function automatic region_rsp_t table_apply(input logic [OP_W-1:0] op,
                                              input logic [VA_W-1:0] base_in,
                                              input logic [PAGES_W-1:0] pages_in);
    region_rsp_t     r;
    longint unsigned b, p, e, cand;
    int unsigned     at;
    b = base_in;
    p = pages_in;
    e = b + p * PG_BYTES;
    r = '0;
    case (op)
      OP_RESERVE: begin
        if (p == 0 || b[11:0] != 0 || b >= lim_reg || e > lim_reg) begin
          r.status = ST_BAD_ARG;
        end else if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          at = tbl_count;
          for (int i = 0; i < tbl_count; i++) begin
            if (spans_overlap(b, p, tbl_base[i], tbl_pages[i])) r.status = ST_OVERLAP;
            if (at == tbl_count && b < tbl_base[i]) at = i;
          end
          if (r.status == ST_OK) begin
            for (int i = tbl_count; i > at; i--) begin
              tbl_base[i]  = tbl_base[i-1];
              tbl_pages[i] = tbl_pages[i-1];
            end
            tbl_base[at]  = b;
            tbl_pages[at] = p;
            tbl_count++;
          end
        end
      end
      OP_CHECK: begin
        r.status = ST_NOT_RESERVED;
        if (p != 0)
          for (int i = 0; i < tbl_count; i++)
            if (b >= tbl_base[i] && e <= tbl_base[i] + tbl_pages[i] * PG_BYTES)
              r.status = ST_OK;
      end
      OP_SELECT: begin
        if (p == 0) begin
          r.status = ST_BAD_ARG;
        end else begin
          r.status = ST_OK;
          cand = ((b != 0) ? b : dflt_reg) & ~64'hFFF;
          for (int i = 0; i < tbl_count; i++)
            if (spans_overlap(cand, p, tbl_base[i], tbl_pages[i])) begin
              if (b != 0) r.status = ST_OVERLAP;
              else cand = (tbl_base[i] + tbl_pages[i] * PG_BYTES + gap_reg + 64'hFFF)
                          & ~64'hFFF;
            end
          if (r.status == ST_OK) begin
            if (cand + p * PG_BYTES > lim_reg || cand > VA_MASK) r.status = ST_NO_SPACE;
            else r.stack_base = cand[VA_W-1:0];
          end
        end
      end
      default: r.status = ST_BAD_ARG;
    endcase
    return r;
  endfunction

  // Short gaps mostly, a few long ones, none inside quiet windows
  function automatic int pick_gap(input bit quiet);
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [VA_W-1:0] base_in,
                           input logic [PAGES_W-1:0] pages_in, input bit typed,
                           input region_rsp_t typed_rsp);
    region_rsp_t r;
    req_ch.operation    = op;
    req_ch.base_address = base_in;
    req_ch.page_count   = pages_in;
    req_ch.valid        = 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    r = table_apply(op, base_in, pages_in);
    pending_results.push_back(typed ? typed_rsp : r);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  task automatic apb_write(input logic [1:0] idx, input longint unsigned val);
    paddr   = {idx, 3'b000};
    pwdata  = val;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_LIMIT: lim_reg  = val & 64'hFFFF_FFFF_FFFF;
      REG_DFLT:  dflt_reg = val & VA_MASK;
      default:   gap_reg  = val & 64'hFFFF_FFFF;
    endcase
  endtask

  // Random word: mostly well-formed addresses clustered where ranges live
  task automatic random_word(output logic [OP_W-1:0] op, output logic [VA_W-1:0] b,
                             output logic [PAGES_W-1:0] p);
    longint unsigned region;
    int              k;
    if ($urandom_range(0, 99) < 15) begin
      op = OP_W'($urandom_range(0, 3));
      b  = VA_W'({$urandom, $urandom});
      p  = PAGES_W'({$urandom, $urandom});
      if ($urandom_range(0, 1)) p = p & 36'hFF;
      return;
    end
    k = $urandom_range(0, 99);
    op = (k < 35) ? OP_RESERVE : (k < 70) ? OP_CHECK : OP_SELECT;
    case ($urandom_range(0, 2))
      0:       region = 64'h10_0000;
      1:       region = dflt_reg & ~64'hFFF;
      default: region = (lim_reg > 64'h40000) ? lim_reg - 64'h40000 : 0;
    endcase
    b = VA_W'((region + $urandom_range(0, 63) * PG_BYTES) & VA_MASK);
    p = PAGES_W'($urandom_range(1, 8));
    if (op == OP_CHECK && tbl_count > 0 && $urandom_range(0, 1)) begin
      k = $urandom_range(0, tbl_count - 1);
      b = VA_W'(tbl_base[k] + $urandom_range(0, 1) * PG_BYTES);
      p = PAGES_W'($urandom_range(0, tbl_pages[k] < 3 ? tbl_pages[k] : 3));
    end
    if (op == OP_SELECT && $urandom_range(0, 1)) b = '0;
    if ($urandom_range(0, 19) == 0) b = b | VA_W'($urandom_range(1, 12'hFFF));
  endtask

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      words_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected response word", rsp_ch.status, 0);
      end else begin
        region_rsp_t e;
        e = pending_results.pop_front();
        if (rsp_ch.status !== e.status)
          report_mismatch("status", rsp_ch.status, e.status);
        if (rsp_ch.stack_base !== e.stack_base)
          report_mismatch("stack_base", rsp_ch.stack_base, e.stack_base);
      end
    end
  end

  // Response ready: random stalls, quiet windows, one long hold-off
  initial begin
    int hold;
    int cyc;
    bit held_long;
    hold = 0;
    cyc = 0;
    held_long = 0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!held_long && words_seen >= 600) begin
        held_long = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready = 1'b0;
      end else begin
        hold = drain_wait ? 0 : pick_gap((cyc % 1000) < 150);
        rsp_ch.ready = (hold == 0);
      end
    end
  end

  // Stimulus
  initial begin
    logic [OP_W-1:0]    op;
    logic [VA_W-1:0]    b;
    logic [PAGES_W-1:0] p;
    region_rsp_t        typed_rsp;
    int                 gap;
    fail_count = 0;
    words_seen = 0;
    drain_wait = 0;
    tbl_count  = 0;
    lim_reg    = LIMIT_RST;
    dflt_reg   = DFLT_RST;
    gap_reg    = GAP_RST;
    req_ch.valid = 1'b0;
    req_ch.operation = '0;
    req_ch.base_address = '0;
    req_ch.page_count = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words
    for (int i = 0; i < N_DIR; i++) begin
      typed_rsp.status     = DIR_ROWS[i].status;
      typed_rsp.stack_base = DIR_ROWS[i].stack_base;
      send_word(DIR_ROWS[i].op, DIR_ROWS[i].base, DIR_ROWS[i].pages,
                DIR_ROWS[i].typed, typed_rsp);
      repeat (pick_gap(0)) @(negedge clk_i);
    end

    // Random phases, registers rewritten while idle between them
    for (int ph = 0; ph < 4; ph++) begin
      drain_wait = 1;
      while (pending_results.size() != 0) @(negedge clk_i);
      repeat (30) @(negedge clk_i);
      drain_wait = 0;
      case (ph)
        0: begin
          apb_write(REG_LIMIT, 64'h0);
          apb_write(REG_DFLT, 64'h0);
          apb_write(REG_GAP, 64'h0);
        end
        1: begin
          apb_write(REG_LIMIT, 64'h8000_0000_0000);
          apb_write(REG_DFLT, 64'h7FFF_FFFF_FFFF);
          apb_write(REG_GAP, 64'hFFFF_FFFF);
        end
        2: begin
          apb_write(REG_LIMIT, {$urandom_range(16'h1000, 16'h8000), 32'h0} | 64'h0);
          apb_write(REG_DFLT, 64'h10_0000 + $urandom_range(0, 32) * PG_BYTES);
          apb_write(REG_GAP, $urandom_range(0, 20000));
        end
        default: begin
          apb_write(REG_LIMIT, LIMIT_RST);
          apb_write(REG_DFLT, DFLT_RST);
          apb_write(REG_GAP, GAP_RST);
        end
      endcase
      for (int n = 0; n < 335; n++) begin
        random_word(op, b, p);
        send_word(op, b, p, 1'b0, '0);
        gap = pick_gap((n % 120) < 25);
        repeat (gap) @(negedge clk_i);
      end
    end

    drain_wait = 1;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0)
      $display("** reserved_region_table: PASSED **");
    else
      $display("** reserved_region_table: FAILED **");
    $finish;
  end

endmodule
